>>> hw/rtl/br4m_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Radix-4 Booth multiplier package
// Widths, Booth digit decoding and the carry-save compressor functions that
// the multiplier uses.
// ----------------------------------------------------------------------------
package br4m_pkg;

  localparam int unsigned OpWidth   = 32;
  localparam int unsigned ProdWidth = 2 * OpWidth;
  localparam int unsigned NumDigits = OpWidth / 2 + 1;
  localparam int unsigned PpWidth   = OpWidth + 1;
  localparam int unsigned RowWide   = ProdWidth + 3;

  typedef logic [ProdWidth-1:0] row_t;

  typedef enum logic [1:0] {
    MagZero = 2'd0,
    MagOne  = 2'd1,
    MagTwo  = 2'd2
  } mag_e;

  typedef struct packed {
    logic neg;
    mag_e mag;
  } digit_t;

  typedef struct packed {
    row_t s;
    row_t c;
  } csa_t;

  // Sign-magnitude digit for one overlapping 3-bit window of the multiplier.
  function automatic digit_t booth_digit(logic [2:0] win);
    digit_t d;
    unique case (win)
      3'b000:  d = '{neg: 1'b0, mag: MagZero};
      3'b001:  d = '{neg: 1'b0, mag: MagOne};
      3'b010:  d = '{neg: 1'b0, mag: MagOne};
      3'b011:  d = '{neg: 1'b0, mag: MagTwo};
      3'b100:  d = '{neg: 1'b1, mag: MagTwo};
      3'b101:  d = '{neg: 1'b1, mag: MagOne};
      3'b110:  d = '{neg: 1'b1, mag: MagOne};
      3'b111:  d = '{neg: 1'b0, mag: MagZero};
      default: d = '{neg: 1'b0, mag: MagZero};
    endcase
    return d;
  endfunction

  function automatic csa_t csa32(row_t a, row_t b, row_t c);
    csa_t r;
    r.s = a ^ b ^ c;
    r.c = ((a & b) | (a & c) | (b & c)) << 1;
    return r;
  endfunction

  // 4:2 compressor built from two chained full-adder rows.
  function automatic csa_t csa42(row_t a, row_t b, row_t c, row_t d);
    row_t t;
    row_t x;
    csa_t r;
    t   = ((b & c) | (b & d) | (c & d)) << 1;
    x   = a ^ b ^ c ^ d;
    r.s = x ^ t;
    r.c = ((a & ~x) | (t & x)) << 1;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/br4m_ppgen.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Booth partial product generator
// Recodes the multiplier into radix-4 digits and forms the aligned partial
// product rows with sign-extension and negation correction bits.
// ----------------------------------------------------------------------------
module br4m_ppgen (
  input  wire logic [br4m_pkg::OpWidth-1:0]                 mplier_i,
  input  wire logic [br4m_pkg::OpWidth-1:0]                 mcand_i,
  output br4m_pkg::row_t [br4m_pkg::NumDigits-1:0]          rows_o
);

  localparam int unsigned PadWidth = 2 * br4m_pkg::NumDigits + 1;

  logic [PadWidth-1:0] padded;

  assign padded = {(PadWidth - br4m_pkg::OpWidth - 1)'(0), mplier_i, 1'b0};

  always_comb begin
    br4m_pkg::digit_t                 dig;
    logic [br4m_pkg::PpWidth-1:0]     pp;
    logic [br4m_pkg::RowWide-1:0]     wide;
    logic                             prev_neg;
    prev_neg = 1'b0;
    for (int k = 0; k < br4m_pkg::NumDigits; k++) begin
      dig = br4m_pkg::booth_digit(padded[2*k +: 3]);
      case (dig.mag)
        br4m_pkg::MagTwo: pp = {mcand_i, 1'b0};
        br4m_pkg::MagOne: pp = {1'b0, mcand_i};
        default:          pp = '0;
      endcase
      if (dig.neg) begin
        pp = ~pp;
      end
      wide = br4m_pkg::RowWide'(pp) << (2 * k);
      if (k == 0) begin
        wide[br4m_pkg::PpWidth]     = dig.neg;
        wide[br4m_pkg::PpWidth + 1] = dig.neg;
        wide[br4m_pkg::PpWidth + 2] = ~dig.neg;
      end else begin
        // If the previous row was inverted, its +1 lands two bits below this row.
        wide[2*k - 2]                     = prev_neg;
        wide[2*k + br4m_pkg::PpWidth]     = ~dig.neg;
        wide[2*k + br4m_pkg::PpWidth + 1] = 1'b1;
      end
      rows_o[k] = wide[br4m_pkg::ProdWidth-1:0];
      prev_neg  = dig.neg;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/booth_radix4_multiplier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Radix-4 Booth multiplier, 32 x 32 -> 64 unsigned
// Three-stage pipeline: Booth rows and first compressor level, remaining
// compressor tree, final carry-propagate adder.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one operand pair per item: tdata holds the
//   multiplier in bits 31:0 and the multiplicand in bits 63:32. The master
//   stream returns the 64-bit unsigned product in tdata, one item for each
//   accepted pair, in order.
//   The product passes through the stage registers l1_q and r16_q, fs_q and
//   fc_q, and prod_q, then shows valid on the master side. One pair can be
//   accepted every cycle while the receiver takes products; each of the three
//   stages passes its item on whenever the stage after it can take it.
//   Each stage has its own valid bit and holds when the stage after it is
//   full and stalled, so bubbles close up while the receiver stalls and the
//   block keeps taking items until all three stages are full. A held
//   product stays stable on the master side until it is taken.
//   Reset clears all valid bits; the block then accepts at once.
// ----------------------------------------------------------------------------
module booth_radix4_multiplier (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  // [31:0] multiplier_in, [63:32] multiplicand_in
  input  wire logic [63:0] s_axis_tdata_i,
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [63:0] product_out
  output      logic [63:0] m_axis_tdata_o
);

  localparam int unsigned Ow = br4m_pkg::OpWidth;

  br4m_pkg::row_t [br4m_pkg::NumDigits-1:0] rows;

  br4m_pkg::row_t [7:0] l1_d, l1_q;
  br4m_pkg::row_t       r16_q;
  br4m_pkg::row_t       fs_d, fs_q, fc_d, fc_q;
  br4m_pkg::row_t       prod_q;
  logic                 v1_q, v2_q, v3_q;
  logic                 en1, en2, en3;

  br4m_ppgen u_ppgen (
    .mplier_i (s_axis_tdata_i[Ow-1:0]),
    .mcand_i  (s_axis_tdata_i[2*Ow-1:Ow]),
    .rows_o   (rows)
  );

  assign en3 = ~v3_q | m_axis_tready_i;
  assign en2 = ~v2_q | en3;
  assign en1 = ~v1_q | en2;

  assign s_axis_tready_o = en1;
  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = prod_q;

  always_comb begin
    br4m_pkg::csa_t r;
    for (int i = 0; i < 4; i++) begin
      r = br4m_pkg::csa42(rows[4*i], rows[4*i+1], rows[4*i+2], rows[4*i+3]);
      l1_d[2*i]   = r.s;
      l1_d[2*i+1] = r.c;
    end
  end

  always_comb begin
    br4m_pkg::csa_t a;
    br4m_pkg::csa_t b;
    br4m_pkg::csa_t c;
    br4m_pkg::csa_t f;
    a    = br4m_pkg::csa42(l1_q[0], l1_q[1], l1_q[2], l1_q[3]);
    b    = br4m_pkg::csa42(l1_q[4], l1_q[5], l1_q[6], l1_q[7]);
    c    = br4m_pkg::csa42(a.s, a.c, b.s, b.c);
    f    = br4m_pkg::csa32(c.s, c.c, r16_q);
    fs_d = f.s;
    fc_d = f.c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= s_axis_tvalid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && s_axis_tvalid_i) begin
      l1_q  <= l1_d;
      r16_q <= rows[br4m_pkg::NumDigits-1];
    end
    if (en2 && v1_q) begin
      fs_q <= fs_d;
      fc_q <= fc_d;
    end
    if (en3 && v2_q) begin
      prod_q <= fs_q + fc_q;
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/br4m_product_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Booth multiplier product checker
// Watches both streams of the radix-4 Booth multiplier. For every accepted
// operand pair it forms the expected product from the Booth rows and queues
// it. Every product taken on the master side is compared with the oldest
// queued value.
// ----------------------------------------------------------------------------
module br4m_product_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire logic                           in_ready_i,
  // [31:0] multiplier, [63:32] multiplicand
  input  wire logic [2*br4m_pkg::OpWidth-1:0] in_data_i,
  input  wire logic                           out_valid_i,
  input  wire logic                           out_ready_i,
  // [63:0] product
  input  wire logic [br4m_pkg::ProdWidth-1:0] out_data_i,
  output int unsigned                         mismatches_o,
  output int unsigned                         pending_o,
  output int unsigned                         checked_o
);

  localparam int unsigned ReportLimit = 10;
  localparam int unsigned Ow          = br4m_pkg::OpWidth;
  localparam int unsigned Pw          = br4m_pkg::ProdWidth;

  logic [Pw-1:0] product_q[$];
  int unsigned   mismatch_cnt = 0;
  int unsigned   checked_cnt  = 0;

  // Adds up the 17 Booth rows, each with its sign-extension constants and the
  // +1 that completes the previous row's inversion.
  function automatic logic [Pw-1:0] booth_product(logic [Ow-1:0] mplier,
                                                  logic [Ow-1:0] mcand);
    logic [Ow+2:0]                  padded;
    logic [2:0]                     win;
    logic                           neg;
    logic                           pos;
    logic                           prev_neg;
    br4m_pkg::mag_e                 mag;
    logic [br4m_pkg::PpWidth-1:0]   pp;
    logic [Pw-1:0]                  row;
    logic [Pw-1:0]                  acc;
    padded   = {2'b00, mplier, 1'b0};
    prev_neg = 1'b0;
    acc      = '0;
    for (int k = 0; k < br4m_pkg::NumDigits; k++) begin
      win = padded[2*k +: 3];
      neg = win[2] & ~(win[1] & win[0]);
      pos = ~neg;
      if (win == 3'b000 || win == 3'b111) begin
        mag = br4m_pkg::MagZero;
      end else if (win == 3'b011 || win == 3'b100) begin
        mag = br4m_pkg::MagTwo;
      end else begin
        mag = br4m_pkg::MagOne;
      end
      case (mag)
        br4m_pkg::MagTwo: pp = {mcand, 1'b0};
        br4m_pkg::MagOne: pp = {1'b0, mcand};
        default:          pp = '0;
      endcase
      if (neg) begin
        pp = ~pp;
      end
      row = Pw'(pp) << (2 * k);
      if (k == 0) begin
        row[33] = row[33] | neg;
        row[34] = row[34] | neg;
        row[35] = row[35] | pos;
      end else begin
        // Constants past the top bit fall off in the shift.
        row = row | (Pw'(prev_neg) << (2 * k - 2));
        row = row | (Pw'(pos) << (2 * k + 33));
        row = row | (Pw'(1'b1) << (2 * k + 34));
      end
      acc      = acc + row;
      prev_neg = neg;
    end
    return acc;
  endfunction

  always @(posedge clk_i) begin
    logic [Pw-1:0] want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        product_q.push_back(booth_product(in_data_i[Ow-1:0],
                                          in_data_i[2*Ow-1:Ow]));
      end
      if (out_valid_i && out_ready_i) begin
        if (product_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= ReportLimit) begin
            $display("MISMATCH @%0t: product %h arrived with no pair outstanding",
                     $realtime, out_data_i);
          end
        end else begin
          want = product_q.pop_front();
          checked_cnt++;
          if (out_data_i !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= ReportLimit) begin
              $display("MISMATCH @%0t: product expected %h, got %h",
                       $realtime, want, out_data_i);
            end
          end
        end
      end
      mismatches_o <= mismatch_cnt;
      pending_o    <= product_q.size();
      checked_o    <= checked_cnt;
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/booth_radix4_multiplier_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Booth multiplier testbench
// Drives operand pairs into the 32 x 32 multiplier: corner operands first,
// then a back-pressure burst and random pairs with and without gaps on both
// streams. The product checker beside the block does all comparisons.
// ----------------------------------------------------------------------------
module booth_radix4_multiplier_tb;

  localparam int unsigned Ow          = br4m_pkg::OpWidth;
  localparam int unsigned Pw          = br4m_pkg::ProdWidth;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned IdlePercent = 15;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic [2*Ow-1:0]       s_axis_tdata  = '0;
  logic                  m_axis_tready = 1'b0;
  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic [Pw-1:0]         m_axis_tdata;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned pairs_sent = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  bit          rx_hold    = 1'b0;

  logic [Ow-1:0] corner_mplier[] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001,
    32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
    32'h3333_3333, 32'hCCCC_CCCC, 32'h6666_6666, 32'h9999_9999, 32'h7FFF_FFFF,
    32'hC000_0000, 32'h0000_0002
  };
  logic [Ow-1:0] corner_mcand[] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
    32'hDEAD_BEEF, 32'h1234_5678
  };

  always #4 clk_i = ~clk_i;

  booth_radix4_multiplier u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  br4m_product_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Full-range values half the time, the rest small values and sparse and dense bit
  // patterns that hit long runs of equal Booth digits.
  function automatic logic [Ow-1:0] pick_operand();
    logic [Ow-1:0] one_hot;
    one_hot = 1 << $urandom_range(Ow - 1);
    case ($urandom_range(7))
      0:       return $urandom_range(1) ? '1 : '0;
      1:       return one_hot;
      2:       return ~one_hot;
      3:       return $urandom_range(255);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_pair(logic [Ow-1:0] mplier, logic [Ow-1:0] mcand);
    if (tx_idle_en && $urandom_range(99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {mcand, mplier};
    do @(posedge clk_i); while (!s_axis_tready);
    pairs_sent++;
  endtask

  task automatic send_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_pair(pick_operand(), pick_operand());
    end
  endtask

  // The pending count is registered, so the task first waits on the clock
  // before it reads it.
  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, or one long hold-off counted here while the
  // sender keeps offering items.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        rx_hold = 1'b0;
      end else begin
        m_axis_tready <= !(rx_idle_en && $urandom_range(99) < IdlePercent);
      end
    end
  end

  initial begin
    #(8 * 200_000);
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_mplier[i]) begin
      send_pair(corner_mplier[i], corner_mcand[i]);
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // Fill the pipeline against a stalled receiver.
    tx_idle_en = 1'b0;
    rx_hold    = 1'b1;
    send_random(24);

    tx_idle_en = 1'b1;
    send_random(600);

    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random(400);

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_random(500);
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Summary: %0d operand pairs sent (corner operands, a back-pressure burst,",
             pairs_sent);
    $display("  random pairs with and without stream gaps); %0d products compared.",
             checked);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
